// ===== rtl/lwbc_pkg.sv =====
// shared types, character codes and helpers of the line/word/byte counter
package lwbc_pkg;

    localparam int CNT_BITS_DEF = 24;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    // report field codes
    localparam logic [1:0] FLD_LINES = 2'd0;
    localparam logic [1:0] FLD_WORDS = 2'd1;
    localparam logic [1:0] FLD_BYTES = 2'd2;

    // classified item that travels from the front to the back
    typedef struct packed {
        logic eoi;
        logic is_lf;
        logic is_ws;
    } t_item;

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_DIGIT,
        ST_SEP
    } t_back_state;

    // number of decimal digits of the largest count
    function automatic int dec_digits(input int bits);
        logic [63:0] maxv;
        logic [63:0] p;
        int          d;
        maxv = (64'd1 << bits) - 64'd1;
        p    = 64'd10;
        d    = 1;
        for (int k = 0; k < 19; k++) begin
            if (p <= maxv) begin
                p = p * 64'd10;
                d = d + 1;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/line_word_byte_counter_core.sv =====
// line, word and byte counter over a byte stream with an ascii report
//
// data bytes are taken one per cycle unless o_in_stall is high: the front
// registers and classifies each transfer, a four-entry queue buffers it,
// and the back updates the line, word and byte counters one item per cycle
// while no report is being printed. every counter keeps a decimal shadow
// next to its binary value, so no division is needed for the report. an
// end-of-input transfer makes the back print "lines words bytes" followed
// by a line feed (marked last), one character per output transfer, then
// clear all counts. the report steps through every decimal digit position
// of each count (NDIG, 8 at the default 24-bit width), leading zeros
// included, but prints no leading zeros; input transfers keep filling the
// queue meanwhile and are held off by o_in_stall once it is full. counts
// wrap modulo 2^COUNT_BITS.
module line_word_byte_counter_core #(
    parameter int COUNT_BITS = lwbc_pkg::CNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_data_byte,
    // report channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_last
);
    import lwbc_pkg::*;

    // decimal digits needed for the largest count
    localparam int NDIG = dec_digits(COUNT_BITS);

    logic  front_valid;
    t_item front_item;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_item q_item;

    // front: input register and byte classification
    lwbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .o_valid     (front_valid),
        .o_item      (front_item),
        .i_full      (q_full)
    );

    // queue decouples the front from report printing in the back
    lwbc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // back: counters, decimal formatter and output register
    lwbc_back #(.COUNT_BITS(COUNT_BITS), .NDIG(NDIG)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

`ifndef SYNTHESIS
    // the back only pops when the queue holds an item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // the last character of a report is always the line feed
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_out_char == CH_LF))
        else $error("last flag on a character other than line feed");

    // every report character is a digit, a space or a line feed
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_char >= CH_ZERO && o_out_char <= (CH_ZERO + 8'd9))
                         || o_out_char == CH_SPACE || o_out_char == CH_LF))
        else $error("report character outside digits, space and line feed");

    // the front only stalls while it holds an item waiting for queue space
    a_stall_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (front_valid && q_full))
        else $error("input stalled without a blocked item");
`endif

endmodule

// ===== rtl/lwbc_front.sv =====
// input stage: takes byte transfers and classifies them for the queue
module lwbc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_cmd,
    input  logic [7:0]      i_data_byte,
    output logic            o_valid,
    output lwbc_pkg::t_item o_item,
    input  logic            i_full
);
    import lwbc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item cls;
    logic  take;

    assign o_stall = r_valid && i_full;
    assign take    = i_valid && !o_stall;

    always_comb begin
        cls.eoi   = i_cmd;
        cls.is_lf = (i_data_byte == CH_LF);
        cls.is_ws = (i_data_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_full) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= cls;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/lwbc_fifo.sv =====
// short queue of classified items between front and back
module lwbc_fifo #(
    parameter int DEPTH = lwbc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lwbc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output lwbc_pkg::t_item o_item
);
    import lwbc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_TOP);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_TOP) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_TOP) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/lwbc_count.sv =====
// wrapping binary counter with a decimal shadow for the report
module lwbc_count #(
    parameter int COUNT_BITS = lwbc_pkg::CNT_BITS_DEF,
    parameter int NDIG       = lwbc_pkg::dec_digits(COUNT_BITS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_inc,
    input  logic                  i_clr,
    output logic [NDIG-1:0][3:0]  o_bcd
);
    import lwbc_pkg::*;

    logic [COUNT_BITS-1:0] r_bin;
    logic [NDIG-1:0][3:0]  r_bcd;
    logic [COUNT_BITS-1:0] n_bin;
    logic [NDIG-1:0][3:0]  n_bcd;
    logic [NDIG-1:0][3:0]  bcd_inc;
    logic [NDIG:0]         carry;
    logic                  wrap;

    assign wrap = &r_bin;

    // decimal increment: a digit steps when every lower digit is nine
    always_comb begin
        carry[0] = 1'b1;
        for (int k = 0; k < NDIG; k++) begin
            carry[k+1] = carry[k] && (r_bcd[k] == 4'd9);
            if (carry[k]) begin
                bcd_inc[k] = (r_bcd[k] == 4'd9) ? 4'd0 : r_bcd[k] + 4'd1;
            end else begin
                bcd_inc[k] = r_bcd[k];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_clr) begin
            n_bin = '0;
            n_bcd = '0;
        end else if (i_inc) begin
            n_bin = r_bin + COUNT_BITS'(1);
            n_bcd = wrap ? '0 : bcd_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
            r_bcd <= '0;
        end else begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_bcd = r_bcd;

endmodule

// ===== rtl/lwbc_back.sv =====
// back end: applies items to the counters and prints the report
module lwbc_back #(
    parameter int COUNT_BITS = lwbc_pkg::CNT_BITS_DEF,
    parameter int NDIG       = lwbc_pkg::dec_digits(COUNT_BITS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  lwbc_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_last
);
    import lwbc_pkg::*;

    localparam int DIG_W = $clog2(NDIG);
    localparam logic [DIG_W-1:0] DIG_TOP = DIG_W'(NDIG - 1);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [1:0]           r_field;
    logic [1:0]           n_field;
    logic [DIG_W-1:0]     r_dig;
    logic [DIG_W-1:0]     n_dig;
    logic                 r_lead;
    logic                 n_lead;
    logic                 r_inside;
    logic                 n_inside;
    logic                 r_valid;
    logic                 n_valid;
    logic [7:0]           r_char;
    logic                 r_last;

    logic [NDIG-1:0][3:0] line_bcd;
    logic [NDIG-1:0][3:0] word_bcd;
    logic [NDIG-1:0][3:0] byte_bcd;
    logic [NDIG-1:0][3:0] sel_bcd;
    logic [3:0]           cur;
    logic                 out_free;
    logic                 skip;
    logic                 emit;
    logic [7:0]           emit_char;
    logic                 emit_last;
    logic                 clr;
    logic                 data_pop;
    logic                 inc_line;
    logic                 inc_word;

    assign out_free = !r_valid || !i_stall;

    always_comb begin
        case (r_field)
            FLD_LINES: sel_bcd = line_bcd;
            FLD_WORDS: sel_bcd = word_bcd;
            default:   sel_bcd = byte_bcd;
        endcase
    end

    assign cur  = sel_bcd[r_dig];
    assign skip = r_lead && (cur == 4'd0) && (r_dig != '0);

    assign data_pop = o_pop && !i_item.eoi;
    assign inc_line = data_pop && i_item.is_lf;
    assign inc_word = data_pop && !i_item.is_ws && !r_inside;

    lwbc_count #(.COUNT_BITS(COUNT_BITS), .NDIG(NDIG)) u_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (inc_line),
        .i_clr   (clr),
        .o_bcd   (line_bcd)
    );

    lwbc_count #(.COUNT_BITS(COUNT_BITS), .NDIG(NDIG)) u_words (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (inc_word),
        .i_clr   (clr),
        .o_bcd   (word_bcd)
    );

    lwbc_count #(.COUNT_BITS(COUNT_BITS), .NDIG(NDIG)) u_bytes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (data_pop),
        .i_clr   (clr),
        .o_bcd   (byte_bcd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COUNT: begin
                if (!i_empty && i_item.eoi) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free && (r_dig == '0)) begin
                    n_state = ST_SEP;
                end
            end
            ST_SEP: begin
                if (out_free) begin
                    n_state = (r_field == FLD_BYTES) ? ST_COUNT : ST_DIGIT;
                end
            end
            default: n_state = ST_COUNT;
        endcase
    end

    // actions per state
    always_comb begin
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = CH_LF;
        emit_last = 1'b0;
        clr       = 1'b0;
        n_field   = r_field;
        n_dig     = r_dig;
        n_lead    = r_lead;
        case (r_state)
            ST_COUNT: begin
                o_pop = !i_empty;
                if (!i_empty && i_item.eoi) begin
                    n_field = FLD_LINES;
                    n_dig   = DIG_TOP;
                    n_lead  = 1'b1;
                end
            end
            ST_DIGIT: begin
                if (skip) begin
                    n_dig = r_dig - DIG_W'(1);
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_char = CH_ZERO + {4'd0, cur};
                    n_lead    = 1'b0;
                    if (r_dig != '0) begin
                        n_dig = r_dig - DIG_W'(1);
                    end
                end
            end
            ST_SEP: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_field == FLD_BYTES) begin
                        emit_char = CH_LF;
                        emit_last = 1'b1;
                        clr       = 1'b1;
                    end else begin
                        emit_char = CH_SPACE;
                        n_field   = r_field + 2'd1;
                        n_dig     = DIG_TOP;
                        n_lead    = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_inside = r_inside;
        if (clr) begin
            n_inside = 1'b0;
        end else if (data_pop) begin
            n_inside = !i_item.is_ws;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (emit) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_COUNT;
            r_field  <= FLD_LINES;
            r_dig    <= '0;
            r_lead   <= 1'b0;
            r_inside <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_field  <= n_field;
            r_dig    <= n_dig;
            r_lead   <= n_lead;
            r_inside <= n_inside;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= emit_char;
            r_last <= emit_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_char = r_char;
    assign o_last     = r_last;

endmodule

// ===== tb/sv/line_word_byte_counter_core_tb.sv =====
// self-checking testbench of the line/word/byte counter core with its report output
module line_word_byte_counter_core_tb;
    import lwbc_pkg::*;

    // narrow counters exercise the width parameter away from its default
    localparam int COUNT_W      = 10;
    // report length at most 3 * 4 digits + 3 separators at this width
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 120;

    // input command codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOI  = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_report_char;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_cmd       = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_last;

    // predicted counter state, mirrors the block after each accepted transfer
    logic [COUNT_W-1:0] tally_lines;
    logic [COUNT_W-1:0] tally_words;
    logic [COUNT_W-1:0] tally_bytes;
    logic               in_word;

    // report characters still owed by the block, oldest first
    t_report_char report_chars_q[$];
    t_report_char head_char;

    int error_cnt;
    int cycle_cnt;

    // sender pacing
    int burst_left;

    // receiver stall pattern and long hold-off request
    int rx_hold_req;
    int rx_hold_left;
    int rx_phase_left;
    int rx_mode;

    line_word_byte_counter_core #(
        .COUNT_BITS(COUNT_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    // decimal digits of one count, most significant first, no leading zeros
    function automatic void push_count_digits(input logic [COUNT_W-1:0] v);
        logic [7:0]         digits[$];
        logic [COUNT_W-1:0] rest;
        rest = v;
        do begin
            digits.push_front(8'(CH_ZERO + rest % 10));
            rest = COUNT_W'(rest / 10);
        end while (rest != 0);
        foreach (digits[k]) report_chars_q.push_back('{ch: digits[k], last: 1'b0});
    endfunction

    // update the predicted counters with one accepted transfer
    function automatic void track_transfer(input logic cmd, input logic [7:0] b);
        if (cmd == CMD_DATA) begin
            tally_bytes = tally_bytes + 1'b1;
            if (b == CH_LF) tally_lines = tally_lines + 1'b1;
            if (is_blank(b)) begin
                in_word = 1'b0;
            end else if (!in_word) begin
                tally_words = tally_words + 1'b1;
                in_word     = 1'b1;
            end
        end else begin
            // end of input: "lines words bytes" then a line feed marked last
            push_count_digits(tally_lines);
            report_chars_q.push_back('{ch: CH_SPACE, last: 1'b0});
            push_count_digits(tally_words);
            report_chars_q.push_back('{ch: CH_SPACE, last: 1'b0});
            push_count_digits(tally_bytes);
            report_chars_q.push_back('{ch: CH_LF, last: 1'b1});
            tally_lines = '0;
            tally_words = '0;
            tally_bytes = '0;
            in_word     = 1'b0;
        end
    endfunction

    // random byte that ends a word run
    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // random byte that belongs to a word, mostly letters, sometimes any non-blank
    function automatic logic [7:0] pick_word_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(97, 122));
        do b = 8'($urandom); while (is_blank(b));
        return b;
    endfunction

    // one input transfer; entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_data_byte <= b;
        // wait for the edge that takes the transfer
        do @(posedge i_clk); while (o_in_stall);
        track_transfer(cmd, b);
        @(negedge i_clk);
        // bursts of random length, random gaps between them
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_item(CMD_DATA, s[k]);
    endtask

    // sender pauses until every owed character has come out
    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        while (report_chars_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // report straight after reset, then twice in a row with nothing between
    task automatic test_empty_report();
        send_item(CMD_EOI, 8'h00);
        send_item(CMD_EOI, 8'hff);
        send_item(CMD_EOI, CH_LF);
        wait_for_reports();
    endtask

    // every blank kind, runs of blanks, leading blanks, byte extremes as word bytes
    task automatic test_word_boundaries();
        send_item(CMD_DATA, CH_SPACE);
        send_item(CMD_DATA, CH_TAB);
        send_text("ab");
        send_item(CMD_DATA, CH_CR);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, CH_LF);
        send_item(CMD_DATA, 8'hff);
        send_item(CMD_DATA, 8'h80);
        send_item(CMD_DATA, CH_LF);
        send_item(CMD_DATA, CH_LF);
        send_text("z");
        // the byte of an end-of-input transfer must be ignored
        send_item(CMD_EOI, 8'hff);
        wait_for_reports();
    endtask

    // the word flag is cleared by a report: a run split by it counts twice
    task automatic test_word_flag_clear();
        send_text("a");
        send_item(CMD_EOI, 8'h61);
        send_text("b");
        send_item(CMD_EOI, CH_SPACE);
        wait_for_reports();
    endtask

    // receiver holds off long while the sender keeps offering, so the input stalls
    task automatic test_report_backpressure();
        send_text("one two\n");
        rx_hold_req = 300;
        send_item(CMD_EOI, 8'h00);
        for (int k = 0; k < 40; k++) send_item(CMD_DATA, pick_word_byte());
        send_item(CMD_EOI, 8'h00);
        send_text("x y");
        send_item(CMD_EOI, 8'h00);
        wait_for_reports();
    endtask

    // text segments with random content closed by end of input, mixed with noise
    task automatic test_random_text();
        int sent;
        int seg_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(1, 25);
            if ($urandom_range(0, 4) != 0) begin
                for (int k = 0; k < seg_len; k++) begin
                    if ($urandom_range(0, 2) == 0) send_item(CMD_DATA, pick_blank());
                    else send_item(CMD_DATA, pick_word_byte());
                end
                send_item(CMD_EOI, 8'($urandom));
                sent += seg_len + 1;
            end else begin
                // raw bytes with an occasional stray end of input
                for (int k = 0; k < seg_len; k++) begin
                    if ($urandom_range(0, 7) == 0) send_item(CMD_EOI, 8'($urandom));
                    else send_item(CMD_DATA, 8'($urandom));
                end
                sent += seg_len;
            end
        end
        send_item(CMD_EOI, 8'($urandom));
        wait_for_reports();
    endtask

    // receiver: stall pattern of its own, in phases, plus a counted long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (rx_phase_left == 0) begin
                // mode 0 never stalls, 1 stalls half the time, 2 now and then
                rx_mode       = $urandom_range(0, 2);
                rx_phase_left = $urandom_range(5, 60);
            end else begin
                rx_phase_left--;
            end
            case (rx_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // checker: every output transfer against the oldest owed character
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (report_chars_q.size() == 0) begin
                $display("%0t: unexpected transfer, char %0d last %0d",
                         $time, o_out_char, o_last);
                error_cnt++;
            end else begin
                head_char = report_chars_q.pop_front();
                if (o_out_char !== head_char.ch) begin
                    $display("%0t: out_char expected %0d actual %0d",
                             $time, head_char.ch, o_out_char);
                    error_cnt++;
                end
                if (o_last !== head_char.last) begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, head_char.last, o_last);
                    error_cnt++;
                end
            end
        end
    end

    // watchdog on a cycle count
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        error_cnt     = 0;
        burst_left    = 0;
        rx_hold_req   = 0;
        rx_hold_left  = 0;
        rx_phase_left = 0;
        rx_mode       = 0;
        tally_lines   = '0;
        tally_words   = '0;
        tally_bytes   = '0;
        in_word       = 1'b0;
        // synchronous reset, applied once at the start
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_report();
        test_word_boundaries();
        test_word_flag_clear();
        test_report_backpressure();
        test_random_text();

        if (error_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lwbc_pkg.sv
rtl/lwbc_front.sv
rtl/lwbc_fifo.sv
rtl/lwbc_count.sv
rtl/lwbc_back.sv
rtl/line_word_byte_counter_core.sv
tb/sv/line_word_byte_counter_core_tb.sv
